FILE: sv/mpqb_pkg.sv
// ----------------------------------------------------------------------------
// mpqb_pkg
// Shared constants, codes and control types of the priority queue bank.
// ----------------------------------------------------------------------------
package mpqb_pkg;

	localparam int DEF_NUM_QUEUES  = 16;
	localparam int DEF_STORE_DEPTH = 256;

	localparam int FUNC_W  = 2;
	localparam int TAG_W   = 16;
	localparam int RANK_W  = 16;
	localparam int QIDX_W  = 4;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 9;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT  = 2'd0,
		FN_EXTRACT = 2'd1,
		FN_MOVE    = 2'd2
	} func_t;

	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRINTED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] ST_MOVED    = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic in_ready;
		logic start;
		logic clear;
		logic scan;
		logic drain;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic op_start;
		logic clr_last;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: sv/mpqb_ram.sv
// ----------------------------------------------------------------------------
// mpqb_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpqb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: sv/mpqb_ctrl.sv
// ----------------------------------------------------------------------------
// mpqb_ctrl
// Sequencer: clear sweep after reset, then accept, scan, drain and finish.
// ----------------------------------------------------------------------------
module mpqb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  mpqb_pkg::dp_stat_t  stat,
	output mpqb_pkg::ctrl_cmd_t cmd
);
	import mpqb_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.op_start) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/mpqb_dpath.sv
// ----------------------------------------------------------------------------
// mpqb_dpath
// Slot store, queue counts, scan registers and result register.
// ----------------------------------------------------------------------------
module mpqb_dpath #(
	parameter int NUM_QUEUES  = mpqb_pkg::DEF_NUM_QUEUES,
	parameter int STORE_DEPTH = mpqb_pkg::DEF_STORE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mpqb_pkg::ctrl_cmd_t               cmd,
	output mpqb_pkg::dp_stat_t                stat,
	input  logic                              in_valid,
	input  logic [mpqb_pkg::FUNC_W-1:0]       in_func,
	input  logic [mpqb_pkg::TAG_W-1:0]        in_tag,
	input  logic [mpqb_pkg::RANK_W-1:0]       in_rank,
	input  logic [mpqb_pkg::QIDX_W-1:0]       in_tq,
	input  logic [mpqb_pkg::QIDX_W-1:0]       in_sq,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mpqb_pkg::STAT_W-1:0]       out_status,
	output logic [mpqb_pkg::TAG_W-1:0]        out_tag,
	output logic [mpqb_pkg::COUNT_W-1:0]      out_count,
	output logic [mpqb_pkg::QIDX_W-1:0]       out_index
);
	import mpqb_pkg::*;

	localparam int QW      = $clog2(NUM_QUEUES);
	localparam int AW      = $clog2(STORE_DEPTH);
	localparam int CW      = $clog2(STORE_DEPTH + 1);
	localparam int WW      = 1 + QW + TAG_W + RANK_W;
	localparam int CLR_LEN = (STORE_DEPTH > NUM_QUEUES) ? STORE_DEPTH : NUM_QUEUES;
	localparam int CLRW    = $clog2(CLR_LEN + 1);

	function automatic logic [QW-1:0] queue_mod(input logic [QIDX_W-1:0] v);
		logic [8:0] r;
		r = 9'(v);
		for (int k = 0; k < 8; k++) begin
			if (r >= 9'(NUM_QUEUES)) begin
				r = r - 9'(NUM_QUEUES);
			end
		end
		return QW'(r);
	endfunction

	logic [FUNC_W-1:0] func_q;
	logic [TAG_W-1:0]  tag_q;
	logic [RANK_W-1:0] rank_q;
	logic [QW-1:0]     tq_q;
	logic [QW-1:0]     sq_q;

	logic [CLRW-1:0]   clr_idx_q;
	logic [AW-1:0]     scan_idx_q;
	logic              valid_s1;
	logic [AW-1:0]     idx_s1;

	logic              found_q;
	logic [AW-1:0]     best_q;
	logic [TAG_W-1:0]  best_tag_q;
	logic [RANK_W-1:0] best_rank_q;
	logic [CW-1:0]     cnt_t_q;
	logic [CW-1:0]     cnt_s_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [TAG_W-1:0]  otag_q;
	logic [COUNT_W-1:0] ocount_q;
	logic [QIDX_W-1:0] oidx_q;

	logic              slot_we;
	logic [AW-1:0]     slot_waddr;
	logic [WW-1:0]     slot_wdata;
	logic [WW-1:0]     slot_rdata;
	logic              cnt_we;
	logic [QW-1:0]     cnt_waddr;
	logic [CW-1:0]     cnt_wdata;
	logic [QW-1:0]     cnt_raddr;
	logic [CW-1:0]     cnt_rdata;

	logic              rd_used;
	logic [QW-1:0]     rd_owner;
	logic [TAG_W-1:0]  rd_tag;
	logic [RANK_W-1:0] rd_rank;
	logic              is_insert;
	logic              is_extract;
	logic              is_move;
	logic              move_real;
	logic              move_hit;

	logic [STAT_W-1:0] res_status;
	logic [TAG_W-1:0]  res_tag;
	logic [CW-1:0]     res_count;
	logic              res_cnt_we;

	assign rd_used  = slot_rdata[WW-1];
	assign rd_owner = slot_rdata[WW-2 -: QW];
	assign rd_tag   = slot_rdata[RANK_W +: TAG_W];
	assign rd_rank  = slot_rdata[RANK_W-1:0];

	assign is_insert  = (func_q == FN_INSERT);
	assign is_extract = (func_q == FN_EXTRACT);
	assign is_move    = (func_q == FN_MOVE);
	assign move_real  = is_move && (sq_q != tq_q);
	assign move_hit   = valid_s1 && move_real && rd_used && (rd_owner == sq_q);

	assign stat.op_start  = in_valid && (in_func inside {FN_INSERT, FN_EXTRACT, FN_MOVE});
	assign stat.clr_last  = (clr_idx_q == CLRW'(CLR_LEN - 1));
	assign stat.scan_last = (scan_idx_q == AW'(STORE_DEPTH - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign cnt_raddr = scan_idx_q[0] ? sq_q : tq_q;

	always_comb begin
		res_status = ST_MOVED;
		res_tag    = '0;
		res_count  = cnt_t_q;
		res_cnt_we = 1'b0;
		case (func_q)
			FN_INSERT: begin
				if (found_q) begin
					res_status = ST_INSERTED;
					res_count  = cnt_t_q + CW'(1);
					res_cnt_we = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			FN_EXTRACT: begin
				if (found_q) begin
					res_status = ST_PRINTED;
					res_tag    = best_tag_q;
					res_count  = (cnt_t_q != '0) ? cnt_t_q - CW'(1) : cnt_t_q;
					res_cnt_we = 1'b1;
				end else begin
					res_status = ST_EMPTY;
					res_count  = '0;
				end
			end
			default: begin
				if (move_real) begin
					res_count  = CW'(cnt_t_q + cnt_s_q);
					res_cnt_we = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_s1;
		slot_wdata = {1'b1, tq_q, rd_tag, rd_rank};
		if (cmd.clear) begin
			slot_we    = (clr_idx_q < CLRW'(STORE_DEPTH));
			slot_waddr = AW'(clr_idx_q);
			slot_wdata = '0;
		end else if (move_hit) begin
			slot_we = 1'b1;
		end else if (cmd.commit) begin
			slot_we    = found_q && (is_insert || is_extract);
			slot_waddr = best_q;
			slot_wdata = is_insert ? {1'b1, tq_q, tag_q, rank_q} : '0;
		end
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = tq_q;
		cnt_wdata = res_count;
		if (cmd.clear) begin
			cnt_we    = (clr_idx_q < CLRW'(NUM_QUEUES));
			cnt_waddr = QW'(clr_idx_q);
			cnt_wdata = '0;
		end else if (cmd.drain) begin
			cnt_we    = move_real;
			cnt_waddr = sq_q;
			cnt_wdata = '0;
		end else if (cmd.commit) begin
			cnt_we = res_cnt_we;
		end
	end

	mpqb_ram #(
		.WIDTH (WW),
		.DEPTH (STORE_DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_we),
		.wr_addr (slot_waddr),
		.wr_data (slot_wdata),
		.rd_addr (scan_idx_q),
		.rd_data (slot_rdata)
	);

	mpqb_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_QUEUES)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (cnt_waddr),
		.wr_data (cnt_wdata),
		.rd_addr (cnt_raddr),
		.rd_data (cnt_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= in_func;
			tag_q  <= in_tag;
			rank_q <= in_rank;
			tq_q   <= queue_mod(in_tq);
			sq_q   <= queue_mod(in_sq);
		end
		idx_s1 <= scan_idx_q;
		if (valid_s1) begin
			if (idx_s1 == AW'(0)) begin
				cnt_t_q <= cnt_rdata;
			end
			if (idx_s1 == AW'(1)) begin
				cnt_s_q <= cnt_rdata;
			end
			if (is_insert && !found_q && !rd_used) begin
				best_q <= idx_s1;
			end
			if (is_extract && rd_used && (rd_owner == tq_q) &&
			    (!found_q || (rd_rank > best_rank_q))) begin
				best_q      <= idx_s1;
				best_tag_q  <= rd_tag;
				best_rank_q <= rd_rank;
			end
		end
		if (cmd.commit) begin
			status_q <= res_status;
			otag_q   <= res_tag;
			ocount_q <= COUNT_W'(res_count);
			oidx_q   <= QIDX_W'(tq_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			scan_idx_q  <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + CLRW'(1);
			end
			if (cmd.start) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end
			valid_s1 <= cmd.scan;
			if (valid_s1) begin
				if (is_insert && !rd_used) begin
					found_q <= 1'b1;
				end
				if (is_extract && rd_used && (rd_owner == tq_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_tag    = otag_q;
	assign out_count  = ocount_q;
	assign out_index  = oidx_q;

endmodule

FILE: sv/mergeable_priority_queue_bank.sv
// ----------------------------------------------------------------------------
// mergeable_priority_queue_bank
// Bank of max-priority job queues sharing one slot store.
// Each result takes one full pass over the slot store through its single read
// port. A new item is accepted only once the result of the last one has been
// committed to the output register; an unused func is accepted and dropped
// with no result. After reset a clearing pass over the slot store and queue
// counts runs before the first item is taken.
// ----------------------------------------------------------------------------
module mergeable_priority_queue_bank #(
	parameter int NUM_QUEUES  = mpqb_pkg::DEF_NUM_QUEUES,
	parameter int STORE_DEPTH = mpqb_pkg::DEF_STORE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// job_tag[15:0], job_rank[31:16], target_queue[35:32], source_queue[39:36]
	input  logic [mpqb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// func[1:0]
	input  logic [mpqb_pkg::FUNC_W-1:0]         s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// printed_tag[15:0], queue_count[24:16], queue_index[28:25], zero[31:29]
	output logic [mpqb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// status[2:0]
	output logic [mpqb_pkg::STAT_W-1:0]         m_axis_tuser
);
	import mpqb_pkg::*;

	ctrl_cmd_t          cmd;
	dp_stat_t           stat;
	logic [TAG_W-1:0]   out_tag;
	logic [COUNT_W-1:0] out_count;
	logic [QIDX_W-1:0]  out_index;

	mpqb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	mpqb_dpath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.STORE_DEPTH (STORE_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_valid   (s_axis_tvalid),
		.in_func    (s_axis_tuser),
		.in_tag     (s_axis_tdata[15:0]),
		.in_rank    (s_axis_tdata[31:16]),
		.in_tq      (s_axis_tdata[35:32]),
		.in_sq      (s_axis_tdata[39:36]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_tag    (out_tag),
		.out_count  (out_count),
		.out_index  (out_index)
	);

	assign s_axis_tready = cmd.in_ready;
	assign m_axis_tdata  = {3'b000, out_index, out_count, out_tag};

endmodule

FILE: test/mergeable_priority_queue_bank_tb.sv
// ----------------------------------------------------------------------------
// mergeable_priority_queue_bank_tb
// Self-checking bench for the priority queue bank. A table of corner cases
// runs first. Random insert, extract and move traffic follows in balanced,
// fill and drain phases. Every result is checked field by field against its table
// entry where given, else against a behavioral model of the shared slot store.
// ----------------------------------------------------------------------------
module mergeable_priority_queue_bank_tb;
	import mpqb_pkg::*;

	localparam int NQ          = DEF_NUM_QUEUES;
	localparam int SLOTS       = DEF_STORE_DEPTH;
	localparam int LATENCY     = DEF_STORE_DEPTH + 3;
	localparam int LIMIT       = 2_000_000;
	localparam int HOLD_CYCLES = 3000;
	localparam int HOLD_AT     = 500;
	localparam int CNT_LO      = TAG_W;
	localparam int QIDX_LO     = TAG_W + COUNT_W;
	localparam int PAD_LO      = QIDX_LO + QIDX_W;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
		logic [QIDX_W-1:0] tq;
		logic [QIDX_W-1:0] sq;
	} job_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [TAG_W-1:0]   tag;
		logic [COUNT_W-1:0] count;
		logic [QIDX_W-1:0]  qidx;
	} job_res_t;

	typedef struct packed {
		job_req_t req;
		logic     typed;
		job_res_t res;
	} stim_row_t;

	localparam job_res_t NO_RES = '0;

	stim_row_t directed_rows [0:24] = '{
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd0,  4'd0},  1'b1, '{ST_EMPTY, 16'h0000, 9'd0, 4'd0}},
		'{'{FN_MOVE,    16'h0000, 16'h0000, 4'd5,  4'd3},  1'b1, '{ST_MOVED, 16'h0000, 9'd0, 4'd5}},
		'{'{FN_INSERT,  16'h0000, 16'h0000, 4'd0,  4'd0},  1'b1,
			'{ST_INSERTED, 16'h0000, 9'd1, 4'd0}},
		'{'{FN_INSERT,  16'hFFFF, 16'hFFFF, 4'd0,  4'd0},  1'b1,
			'{ST_INSERTED, 16'h0000, 9'd2, 4'd0}},
		'{'{FN_INSERT,  16'h1234, 16'h8000, 4'd15, 4'd0},  1'b1,
			'{ST_INSERTED, 16'h0000, 9'd1, 4'd15}},
		'{'{FN_UNUSED,  16'hFFFF, 16'hFFFF, 4'd15, 4'd15}, 1'b0, NO_RES},
		'{'{FN_INSERT,  16'hAAAA, 16'h8000, 4'd15, 4'd0},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd0,  4'd0},  1'b1,
			'{ST_PRINTED, 16'hFFFF, 9'd1, 4'd0}},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd0,  4'd0},  1'b1,
			'{ST_PRINTED, 16'h0000, 9'd0, 4'd0}},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd0,  4'd0},  1'b1, '{ST_EMPTY, 16'h0000, 9'd0, 4'd0}},
		'{'{FN_MOVE,    16'h0000, 16'h0000, 4'd0,  4'd15}, 1'b0, NO_RES},
		'{'{FN_MOVE,    16'h0000, 16'h0000, 4'd0,  4'd0},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd0,  4'd0},  1'b0, NO_RES},
		'{'{FN_INSERT,  16'h5555, 16'h0001, 4'd15, 4'd0},  1'b0, NO_RES},
		'{'{FN_INSERT,  16'h0F0F, 16'h7FFF, 4'd7,  4'd15}, 1'b0, NO_RES},
		'{'{FN_MOVE,    16'h0000, 16'h0000, 4'd15, 4'd7},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd15, 4'd0},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd15, 4'd0},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd15, 4'd0},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd15, 4'd0},  1'b0, NO_RES},
		'{'{FN_UNUSED,  16'h0000, 16'h0000, 4'd0,  4'd0},  1'b0, NO_RES},
		'{'{FN_INSERT,  16'hFFFF, 16'h0000, 4'd8,  4'd0},  1'b1,
			'{ST_INSERTED, 16'h0000, 9'd1, 4'd8}},
		'{'{FN_MOVE,    16'h0000, 16'h0000, 4'd9,  4'd8},  1'b0, NO_RES},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd8,  4'd0},  1'b1, '{ST_EMPTY, 16'h0000, 9'd0, 4'd8}},
		'{'{FN_EXTRACT, 16'h0000, 16'h0000, 4'd9,  4'd0},  1'b0, NO_RES}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [FUNC_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0]     m_axis_tuser;

	bit                slot_busy [SLOTS];
	bit [QIDX_W-1:0]   slot_queue [SLOTS];
	bit [TAG_W-1:0]    held_tag [SLOTS];
	bit [RANK_W-1:0]   held_rank [SLOTS];
	bit [COUNT_W-1:0]  queue_jobs [NQ];

	job_res_t pending_results [$];

	bit quiet;
	bit hold_done;
	int hold_left;
	int transfers_in;
	int cycle_count;
	int mismatches;
	int results_seen;
	int func_seen [4];
	int status_seen [8];

	mergeable_priority_queue_bank dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit predict_queue_result(input job_req_t rq, output job_res_t rs);
		int s;
		int best;
		logic [QIDX_W-1:0] tq;
		logic [QIDX_W-1:0] sq;
		tq = rq.tq;
		sq = rq.sq;
		rs = '0;
		rs.qidx = tq;
		best = -1;
		if (rq.func == FN_UNUSED)
			return 1'b0;
		case (rq.func)
			FN_INSERT: begin
				s = 0;
				while (s < SLOTS && slot_busy[s])
					s++;
				if (s == SLOTS) begin
					rs.status = ST_FULL;
				end else begin
					slot_busy[s] = 1'b1;
					slot_queue[s] = tq;
					held_tag[s] = rq.tag;
					held_rank[s] = rq.rank;
					queue_jobs[tq]++;
					rs.status = ST_INSERTED;
				end
				rs.count = queue_jobs[tq];
			end
			FN_EXTRACT: begin
				for (s = 0; s < SLOTS; s++)
					if (slot_busy[s] && slot_queue[s] == tq &&
					    (best < 0 || held_rank[s] > held_rank[best]))
						best = s;
				if (best < 0) begin
					rs.status = ST_EMPTY;
				end else begin
					slot_busy[best] = 1'b0;
					if (queue_jobs[tq] > 0)
						queue_jobs[tq]--;
					rs.status = ST_PRINTED;
					rs.tag = held_tag[best];
					rs.count = queue_jobs[tq];
				end
			end
			default: begin
				if (sq != tq) begin
					for (s = 0; s < SLOTS; s++)
						if (slot_busy[s] && slot_queue[s] == sq)
							slot_queue[s] = tq;
					queue_jobs[tq] += queue_jobs[sq];
					queue_jobs[sq] = '0;
				end
				rs.status = ST_MOVED;
				rs.count = queue_jobs[tq];
			end
		endcase
		return 1'b1;
	endfunction

	function automatic job_req_t random_job(input mix_t mix);
		job_req_t rq;
		int roll;
		int ins_pct;
		int ext_pct;
		roll = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				ins_pct = 88;
				ext_pct = 5;
			end
			MIX_DRAIN: begin
				ins_pct = 12;
				ext_pct = 80;
			end
			default: begin
				ins_pct = 45;
				ext_pct = 35;
			end
		endcase
		rq.tag = TAG_W'($urandom);
		case ($urandom_range(9))
			0, 1: rq.rank = RANK_W'($urandom_range(7));
			2: rq.rank = '1;
			3: rq.rank = '0;
			default: rq.rank = RANK_W'($urandom);
		endcase
		rq.tq = QIDX_W'(($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(NQ - 1));
		rq.sq = QIDX_W'(($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(NQ - 1));
		if (roll < 3)
			rq.func = FN_UNUSED;
		else if (roll < 3 + ins_pct)
			rq.func = FN_INSERT;
		else if (roll < 3 + ins_pct + ext_pct)
			rq.func = FN_EXTRACT;
		else
			rq.func = FN_MOVE;
		return rq;
	endfunction

	// Entered and left at a falling edge.
	task automatic offer_job(input job_req_t rq, input logic typed, input job_res_t typed_res);
		job_res_t res;
		int gap;
		gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= rq.func;
		s_axis_tdata <= {rq.sq, rq.tq, rq.rank, rq.tag};
		do @(posedge clk); while (!s_axis_tready);
		transfers_in++;
		func_seen[rq.func]++;
		if (predict_queue_result(rq, res))
			pending_results.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(input mix_t mix, input int jobs);
		job_req_t rq;
		int done;
		done = 0;
		while (done < jobs) begin
			rq = random_job(mix);
			offer_job(rq, 1'b0, NO_RES);
			if (rq.func != FN_UNUSED)
				done++;
		end
	endtask

	// Hold the output side off once for a long stretch, else stall at random outside quiet phases.
	always @(negedge clk) begin
		if (!hold_done && transfers_in >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(99) >= 30);
		end
	end

	always @(posedge clk) begin : result_check
		job_res_t got;
		job_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.tag = m_axis_tdata[TAG_W-1:0];
			got.count = m_axis_tdata[QIDX_LO-1:CNT_LO];
			got.qidx = m_axis_tdata[PAD_LO-1:QIDX_LO];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transfer, status %0d tag %h count %0d queue %0d",
					$time, got.status, got.tag, got.count, got.qidx);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
					mismatches++;
				end
				if (got.tag !== want.tag) begin
					$display("%0t: printed_tag expected %h actual %h", $time, want.tag, got.tag);
					mismatches++;
				end
				if (got.count !== want.count) begin
					$display("%0t: queue_count expected %0d actual %0d", $time, want.count,
						got.count);
					mismatches++;
				end
				if (got.qidx !== want.qidx) begin
					$display("%0t: queue_index expected %0d actual %0d", $time, want.qidx,
						got.qidx);
					mismatches++;
				end
				if (m_axis_tdata[OUT_DATA_W-1:PAD_LO] !== '0) begin
					$display("%0t: pad bits expected 0 actual %b", $time,
						m_axis_tdata[OUT_DATA_W-1:PAD_LO]);
					mismatches++;
				end
			end
			if (got.status <= ST_FULL)
				status_seen[got.status]++;
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		job_req_t rq;
		int q;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			offer_job(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
		wait_all_results();

		run_phase(MIX_BALANCED, 330);
		wait_all_results();
		run_phase(MIX_FILL, 350);
		// gather the whole store into queue 0
		for (q = 1; q < NQ; q++) begin
			rq = '{FN_MOVE, TAG_W'($urandom), RANK_W'($urandom), QIDX_W'(0), QIDX_W'(q)};
			offer_job(rq, 1'b0, NO_RES);
		end
		run_phase(MIX_DRAIN, 300);
		quiet = 1'b1;
		run_phase(MIX_BALANCED, 150);
		quiet = 1'b0;
		run_phase(MIX_BALANCED, 130);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("Covered %0d inserts, %0d extracts, %0d moves and %0d ignored func codes",
			func_seen[FN_INSERT], func_seen[FN_EXTRACT], func_seen[FN_MOVE], func_seen[FN_UNUSED]);
		$display("Checked %0d results: %0d printed, %0d empty, %0d store full, %0d errors",
			results_seen, status_seen[ST_PRINTED], status_seen[ST_EMPTY], status_seen[ST_FULL],
			mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
